>>> design/assert_macros.svh
// Assertion helpers for the design files; only sue_outq uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Check that the consequent holds in the same cycle as the antecedent.
`define SUE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define SUE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define SUE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SUE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> design/sue_pkg.sv
package sue_pkg;

	localparam int FRAME_LEN_DEF      = 320;
	localparam int HISTORY_FRAMES_DEF = 25;

	localparam int VALID_W  = 9;
	localparam int ENERGY_W = 39;
	localparam int POS_W    = 48;
	localparam int ID_W     = 32;
	localparam int HELD_W   = 48;
	localparam int PRE_W    = 13;
	localparam int RUN_W    = 3;
	localparam int TSIL_W   = 15;
	localparam int SIL_W    = 14;
	localparam int MAXU_W   = 18;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 39;

	localparam logic [RUN_W-1:0]  RUN_SAT  = 3'd7;
	localparam logic [TSIL_W-1:0] TSIL_SAT = 15'd32767;

	localparam logic [ENERGY_W-1:0] ENERGY_THRESHOLD_RST = 39'd3436;
	localparam logic [RUN_W-1:0]    START_RUN_RST        = 3'd5;
	localparam logic [SIL_W-1:0]    SILENCE_RST          = 14'd11200;
	localparam logic [MAXU_W-1:0]   MAX_UTT_RST          = 18'd240000;
	localparam logic [PRE_W-1:0]    PREROLL_RST          = 13'd4800;

	localparam logic OP_FRAME  = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENERGY_THRESHOLD = 3'd0,
		CFG_START_RUN_FRAMES = 3'd1,
		CFG_SILENCE_SAMPLES  = 3'd2,
		CFG_MAX_UTTERANCE    = 3'd3,
		CFG_PREROLL_LIMIT    = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		RSN_SILENCE      = 2'd0,
		RSN_LIMIT        = 2'd1,
		RSN_STOP         = 2'd2,
		RSN_AFTER_FINISH = 2'd3
	} reason_t;

	typedef struct packed {
		logic                op;
		logic                vad_positive;
		logic [ENERGY_W-1:0] frame_energy;
		logic [VALID_W-1:0]  valid_samples;
	} frame_t;

	typedef struct packed {
		logic [ID_W-1:0]  utterance_id;
		logic [POS_W-1:0] first_pos;
		logic [POS_W-1:0] stop_pos;
		reason_t          reason;
	} result_t;

	typedef struct packed {
		logic [ENERGY_W-1:0] energy_threshold;
		logic [RUN_W-1:0]    start_run_frames;
		logic [SIL_W-1:0]    silence_samples;
		logic [MAXU_W-1:0]   max_utterance_samples;
		logic [PRE_W-1:0]    preroll_limit;
	} cfg_t;

endpackage

>>> design/sue_core.sv
module sue_core #(
	parameter int FRAME_LEN      = sue_pkg::FRAME_LEN_DEF,
	parameter int HISTORY_FRAMES = sue_pkg::HISTORY_FRAMES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sue_pkg::cfg_t    cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  sue_pkg::frame_t  in_data,
	input  logic             q_full,
	output logic             push,
	output sue_pkg::result_t push_data
);

	localparam int HW       = HISTORY_FRAMES;
	localparam int CW       = $clog2(HISTORY_FRAMES + 1);
	localparam int DW       = (HISTORY_FRAMES > 1) ? $clog2(HISTORY_FRAMES) : 1;
	localparam int BACK_MAX = (HISTORY_FRAMES - 1) * FRAME_LEN;
	localparam int BW       = (BACK_MAX > 0) ? $clog2(BACK_MAX + 1) : 1;
	localparam int CLAMP    = (FRAME_LEN < 511) ? FRAME_LEN : 511;

	localparam int VW = sue_pkg::VALID_W;
	localparam int PW = sue_pkg::POS_W;
	localparam int HL = sue_pkg::HELD_W;

	// input stage
	sue_pkg::frame_t item_s1;
	logic            vld_s1;
	logic            process;

	// stream state
	logic [PW-1:0]                pos_q, ustart_q;
	logic [HL-1:0]                held_q;
	logic [sue_pkg::PRE_W-1:0]    pre_q;
	logic [sue_pkg::RUN_W-1:0]    vrun_q;
	logic [sue_pkg::TSIL_W-1:0]   tsil_q;
	logic [sue_pkg::ID_W-1:0]     cur_id_q, next_num_q;
	logic [HW-1:0]                hist_q;
	logic [CW-1:0]                hcnt_q;
	logic                         done_q;

	logic [PW-1:0]                pos_w, ustart_w;
	logic [HL-1:0]                held_w;
	logic [sue_pkg::PRE_W-1:0]    pre_w;
	logic [sue_pkg::RUN_W-1:0]    vrun_w;
	logic [sue_pkg::TSIL_W-1:0]   tsil_w;
	logic [sue_pkg::ID_W-1:0]     cur_id_w, next_num_w;
	logic [HW-1:0]                hist_w;
	logic [CW-1:0]                hcnt_w;
	logic                         done_w;

	logic [VW-1:0]                vclamp;
	logic                         voiced;
	logic [sue_pkg::PRE_W:0]      pre_sum;
	logic [sue_pkg::TSIL_W:0]     tsil_sum;
	logic                         check;
	logic [HW-1:0]                zmask;
	logic [DW-1:0]                dsel;
	logic                         found;
	logic [BW-1:0]                back;
	logic [HL-1:0]                maxu;
	logic [HL-1:0]                cut;
	logic                         emit;
	logic [HL-1:0]                emit_cnt;
	sue_pkg::reason_t             emit_rsn;
	logic                         late;
	logic [PW-1:0]                end_pos;

	assign process  = vld_s1 && !q_full;
	assign in_ready = !vld_s1 || !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (process) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	assign vclamp = (item_s1.valid_samples > VW'(CLAMP)) ? VW'(CLAMP) : item_s1.valid_samples;
	assign voiced = item_s1.vad_positive &&
		(item_s1.frame_energy >= cfg.energy_threshold);
	assign maxu   = HL'(cfg.max_utterance_samples);

	always_comb begin
		pos_w      = pos_q;
		ustart_w   = ustart_q;
		held_w     = held_q;
		pre_w      = pre_q;
		vrun_w     = vrun_q;
		tsil_w     = tsil_q;
		cur_id_w   = cur_id_q;
		next_num_w = next_num_q;
		hist_w     = hist_q;
		hcnt_w     = hcnt_q;
		done_w     = done_q;
		pre_sum    = '0;
		tsil_sum   = '0;
		check      = 1'b0;
		emit       = 1'b0;
		emit_cnt   = '0;
		emit_rsn   = sue_pkg::RSN_SILENCE;
		late       = 1'b0;
		zmask      = '0;
		dsel       = '0;
		found      = 1'b0;
		back       = '0;
		cut        = '0;

		if (item_s1.op == sue_pkg::OP_FINISH) begin
			if (!done_q) begin
				done_w = 1'b1;
				if (held_q != '0) begin
					emit     = 1'b1;
					emit_cnt = held_q;
					emit_rsn = sue_pkg::RSN_STOP;
				end else begin
					pre_w = '0;
				end
			end
		end else if (done_q) begin
			late = 1'b1;
		end else begin
			pos_w  = pos_q + PW'(vclamp);
			hist_w = HW'({hist_q, voiced});
			if (hcnt_q < CW'(HISTORY_FRAMES)) begin
				hcnt_w = hcnt_q + CW'(1);
			end

			if (held_q == '0) begin
				pre_sum = {1'b0, pre_q} + (sue_pkg::PRE_W + 1)'(vclamp);
				pre_w   = (pre_sum > {1'b0, cfg.preroll_limit}) ? cfg.preroll_limit :
					pre_sum[sue_pkg::PRE_W-1:0];
				if (voiced) begin
					vrun_w = (vrun_q == sue_pkg::RUN_SAT) ? vrun_q : vrun_q + 3'd1;
				end else begin
					vrun_w = '0;
				end
				// open: id is taken even when the preroll is empty
				if (vrun_w >= cfg.start_run_frames) begin
					cur_id_w   = next_num_q;
					next_num_w = next_num_q + 32'd1;
					ustart_w   = pos_w - PW'(pre_w);
					held_w     = HL'(pre_w);
					pre_w      = '0;
					tsil_w     = '0;
					check      = 1'b1;
				end
			end else begin
				held_w   = held_q + HL'(vclamp);
				tsil_sum = {1'b0, tsil_q} + (sue_pkg::TSIL_W + 1)'(vclamp);
				if (voiced) begin
					tsil_w = '0;
				end else if (tsil_sum[sue_pkg::TSIL_W]) begin
					tsil_w = sue_pkg::TSIL_SAT;
				end else begin
					tsil_w = tsil_sum[sue_pkg::TSIL_W-1:0];
				end
				check = 1'b1;
			end

			// newest unvoiced frame inside the filled part of the history
			for (int i = 0; i < HW; i++) begin
				zmask[i] = !hist_w[i] && (i < int'(hcnt_w));
			end
			for (int i = HW - 1; i >= 0; i--) begin
				if (zmask[i]) begin
					dsel  = DW'(i);
					found = 1'b1;
				end
			end
			back = BW'(dsel * FRAME_LEN);
			cut  = (found && (HL'(back) < held_w)) ? held_w - HL'(back) : maxu;
			if (cut > maxu) begin
				cut = maxu;
			end
			if ((cut == '0) || (cut > held_w)) begin
				cut = held_w;
			end

			if (check && (held_w != '0)) begin
				if (HL'(tsil_w) >= HL'(cfg.silence_samples)) begin
					emit     = 1'b1;
					emit_cnt = held_w;
					emit_rsn = sue_pkg::RSN_SILENCE;
				end else if (held_w >= maxu) begin
					emit     = 1'b1;
					emit_cnt = cut;
					emit_rsn = sue_pkg::RSN_LIMIT;
				end
			end
		end

		end_pos = ustart_w + PW'(emit_cnt);

		push_data = '0;
		push_data.reason = sue_pkg::RSN_AFTER_FINISH;
		if (emit) begin
			push_data.utterance_id = cur_id_w;
			push_data.first_pos    = ustart_w;
			push_data.stop_pos     = end_pos;
			push_data.reason       = emit_rsn;
			ustart_w   = end_pos;
			cur_id_w   = next_num_w;
			next_num_w = next_num_w + 32'd1;
			held_w     = held_w - emit_cnt;
			tsil_w     = '0;
			vrun_w     = '0;
			pre_w      = '0;
			hist_w     = '0;
			hcnt_w     = '0;
		end
		push = process && (emit || late);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			ustart_q   <= '0;
			held_q     <= '0;
			pre_q      <= '0;
			vrun_q     <= '0;
			tsil_q     <= '0;
			cur_id_q   <= '0;
			next_num_q <= '0;
			hist_q     <= '0;
			hcnt_q     <= '0;
			done_q     <= 1'b0;
		end else if (process) begin
			pos_q      <= pos_w;
			ustart_q   <= ustart_w;
			held_q     <= held_w;
			pre_q      <= pre_w;
			vrun_q     <= vrun_w;
			tsil_q     <= tsil_w;
			cur_id_q   <= cur_id_w;
			next_num_q <= next_num_w;
			hist_q     <= hist_w;
			hcnt_q     <= hcnt_w;
			done_q     <= done_w;
		end
	end

endmodule

>>> design/sue_outq.sv
`include "assert_macros.svh"

module sue_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sue_pkg::result_t push_data,
	output logic             q_full,
	output logic             out_valid,
	input  logic             out_ready,
	output sue_pkg::result_t out_data
);

	localparam logic [1:0] CNT_FULL = 2'd2;

	sue_pkg::result_t ent_q [2];
	logic             wptr_q, rptr_q;
	logic [1:0]       cnt_q;
	logic             pop;

	assign q_full    = (cnt_q == CNT_FULL);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = ent_q[rptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= push_data;
		end
	end

	`SUE_ASSERT_IMP(a_no_push_full, clk, arst_n, push, cnt_q != CNT_FULL)
	`SUE_ASSERT_NXT(a_cnt_up, clk, arst_n, push && !pop, cnt_q == 2'($past(cnt_q) + 2'd1))
	`SUE_ASSERT_NXT(a_cnt_down, clk, arst_n, pop && !push, cnt_q == 2'($past(cnt_q) - 2'd1))

endmodule

>>> design/speech_utterance_endpointer_top.sv
// Channel   Dir  Signals                           Beat moves
// -------   ---  --------------------------------  ------------------------------
// in        in   in_valid, in_ready, in_data       one frame summary or finish
// out       out  out_valid, out_ready, out_data    one closed utterance record
// cfg       in   cfg_we, cfg_index, cfg_wdata      one register write, no wait
//
// One input beat per cycle sustained while in is not stalled.
// A result passes the input register, then the queue, before it shows on out.
// The two-entry result queue sets the rate: in stalls only when the input register
// holds a beat and both queue entries wait on out_ready.
// arst_n clears all stream state, the queue and the registers to their reset values.
// No clearing pass; the block takes beats right after reset.
module speech_utterance_endpointer_top #(
	parameter int FRAME_LEN      = sue_pkg::FRAME_LEN_DEF,
	parameter int HISTORY_FRAMES = sue_pkg::HISTORY_FRAMES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sue_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sue_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  sue_pkg::frame_t                 in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output sue_pkg::result_t                out_data
);

	sue_pkg::cfg_t    cfg_q;
	logic             q_full;
	logic             push;
	sue_pkg::result_t push_data;

	// Register file: writes to indexes beyond the list drop silently.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.energy_threshold      <= sue_pkg::ENERGY_THRESHOLD_RST;
			cfg_q.start_run_frames      <= sue_pkg::START_RUN_RST;
			cfg_q.silence_samples       <= sue_pkg::SILENCE_RST;
			cfg_q.max_utterance_samples <= sue_pkg::MAX_UTT_RST;
			cfg_q.preroll_limit         <= sue_pkg::PREROLL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sue_pkg::CFG_ENERGY_THRESHOLD: begin
					cfg_q.energy_threshold <= cfg_wdata[sue_pkg::ENERGY_W-1:0];
				end
				sue_pkg::CFG_START_RUN_FRAMES: begin
					cfg_q.start_run_frames <= cfg_wdata[sue_pkg::RUN_W-1:0];
				end
				sue_pkg::CFG_SILENCE_SAMPLES: begin
					cfg_q.silence_samples <= cfg_wdata[sue_pkg::SIL_W-1:0];
				end
				sue_pkg::CFG_MAX_UTTERANCE: begin
					cfg_q.max_utterance_samples <= cfg_wdata[sue_pkg::MAXU_W-1:0];
				end
				sue_pkg::CFG_PREROLL_LIMIT: begin
					cfg_q.preroll_limit <= cfg_wdata[sue_pkg::PRE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Endpoint decision: input register plus the state update.
	sue_core #(
		.FRAME_LEN      (FRAME_LEN),
		.HISTORY_FRAMES (HISTORY_FRAMES)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	// Result queue: holds finished records so the input side keeps moving.
	sue_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
	import sue_pkg::*;

	// Run shape
	localparam int          LIMIT_CYCLES    = 400000;
	localparam int          SETTLE_CYCLES   = 6;    // result passes the input register, then the queue
	localparam int          LONG_HOLD       = 300;
	localparam int          ITEMS_PER_PHASE = 290;
	localparam int          HIST            = HISTORY_FRAMES_DEF;
	localparam logic [63:0] ENERGY_MAX      = (64'd1 << ENERGY_W) - 1;
	localparam logic [63:0] ENERGY_HIGH     = 64'd343597383680;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	frame_t                in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	result_t               out_data;

	speech_utterance_endpointer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Beats waiting for the driver, and utterance records the block still owes us.
	frame_t  frame_q[$];
	result_t pending_utterances[$];

	// Append a beat at the tail of the driver queue.
	function automatic void add_frame(input frame_t f);
		frame_q.insert(frame_q.size(), f);
	endfunction

	// Append a record at the tail of the expected list.
	function automatic void owe_record(input result_t r);
		pending_utterances.insert(pending_utterances.size(), r);
	endfunction

	bit      in_took       = 1'b0;  // the driven beat was taken at the last rising edge
	bit      no_idle       = 1'b0;  // closing stretch: both sides run flat out
	bit      long_hold_go  = 1'b0;  // ask the receiver for one long back-pressure stretch
	int      mismatches    = 0;
	int      send_gap      = 0;
	int      stall_left    = 0;
	bit      hold_served   = 1'b0;
	result_t want;

	// Shadow of the register file, kept in step with every write we issue.
	cfg_t cfg_shadow = '{
		energy_threshold:      ENERGY_THRESHOLD_RST,
		start_run_frames:      START_RUN_RST,
		silence_samples:       SILENCE_RST,
		max_utterance_samples: MAX_UTT_RST,
		preroll_limit:         PREROLL_RST
	};

	// Predictor state, all zero out of reset.
	logic [POS_W-1:0]  stream_pos  = '0;
	logic [HELD_W-1:0] held_len    = '0;   // zero means no utterance is open
	logic [PRE_W-1:0]  preroll_len = '0;
	logic [RUN_W-1:0]  run_len     = '0;
	logic [TSIL_W-1:0] trail_len   = '0;
	logic [POS_W-1:0]  utt_start   = '0;
	logic [ID_W-1:0]   cur_id      = '0;
	logic [ID_W-1:0]   next_num    = '0;
	logic [HIST-1:0]   voice_hist  = '0;   // bit 0 is the newest frame
	logic [4:0]        hist_count  = '0;
	bit                stream_done = 1'b0;

	// Close the open utterance after count samples and hand the rest on to the next id.
	task automatic emit_utterance(input logic [HELD_W-1:0] count, input reason_t why);
		result_t rec;
		rec.utterance_id = cur_id;
		rec.first_pos    = utt_start;
		rec.stop_pos     = utt_start + count;
		rec.reason       = why;
		owe_record(rec);
		utt_start   = rec.stop_pos;
		cur_id      = next_num;
		next_num    = next_num + 1'b1;
		held_len    = held_len - count;
		trail_len   = '0;
		run_len     = '0;
		preroll_len = '0;
		voice_hist  = '0;
		hist_count  = '0;
	endtask

	// Advance the endpointer by one accepted beat and queue any record it closes.
	task automatic advance_endpointer(input frame_t f);
		logic [VALID_W-1:0] n;
		logic               voiced;
		logic [PRE_W:0]     pre_sum;
		logic [TSIL_W:0]    sil_sum;
		logic [HELD_W-1:0]  cut;
		logic [HELD_W-1:0]  back;
		bit                 judge;
		bit                 found;
		result_t            late_rec;
		if (f.op == OP_FINISH) begin
			// a second finish is dropped without a record
			if (!stream_done) begin
				stream_done = 1'b1;
				if (held_len != 0)
					emit_utterance(held_len, RSN_STOP);
				else
					preroll_len = '0;
			end
		end else if (stream_done) begin
			// frame after finish: state holds, record carries only the reason
			late_rec        = '0;
			late_rec.reason = RSN_AFTER_FINISH;
			owe_record(late_rec);
		end else begin
			n      = (f.valid_samples > FRAME_LEN_DEF) ? VALID_W'(FRAME_LEN_DEF) : f.valid_samples;
			voiced = f.vad_positive && (f.frame_energy >= cfg_shadow.energy_threshold);
			stream_pos = stream_pos + n;
			voice_hist = {voice_hist[HIST-2:0], voiced};
			if (hist_count < HIST)
				hist_count = hist_count + 1'b1;
			judge = 1'b1;
			if (held_len == 0) begin
				pre_sum     = preroll_len + n;
				preroll_len = (pre_sum > cfg_shadow.preroll_limit) ?
				              cfg_shadow.preroll_limit : pre_sum[PRE_W-1:0];
				if (voiced) begin
					if (run_len != RUN_SAT)
						run_len = run_len + 1'b1;
				end else begin
					run_len = '0;
				end
				if (run_len < cfg_shadow.start_run_frames) begin
					judge = 1'b0;
				end else begin
					// open: an id is spent even when the preroll is empty
					cur_id      = next_num;
					next_num    = next_num + 1'b1;
					utt_start   = stream_pos - preroll_len;
					held_len    = HELD_W'(preroll_len);
					preroll_len = '0;
					trail_len   = '0;
				end
			end else begin
				held_len = held_len + n;
				if (voiced) begin
					trail_len = '0;
				end else begin
					sil_sum   = trail_len + n;
					trail_len = (sil_sum > TSIL_SAT) ? TSIL_SAT : sil_sum[TSIL_W-1:0];
				end
			end
			if (judge && held_len != 0) begin
				if (trail_len >= cfg_shadow.silence_samples) begin
					emit_utterance(held_len, RSN_SILENCE);
				end else if (held_len >= cfg_shadow.max_utterance_samples) begin
					// split at the newest unvoiced frame if it lies inside the utterance
					cut   = HELD_W'(cfg_shadow.max_utterance_samples);
					found = 1'b0;
					for (int d = 0; d < HIST; d++) begin
						if (!found && d < hist_count && !voice_hist[d]) begin
							found = 1'b1;
							back  = HELD_W'(d * FRAME_LEN_DEF);
							if (back < held_len)
								cut = held_len - back;
						end
					end
					if (cut > cfg_shadow.max_utterance_samples)
						cut = HELD_W'(cfg_shadow.max_utterance_samples);
					if (cut == 0 || cut > held_len)
						cut = held_len;
					emit_utterance(cut, RSN_LIMIT);
				end
			end
		end
	endtask

	// Stimulus helpers
	function automatic logic [ENERGY_W-1:0] any_energy();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[ENERGY_W-1:0];
	endfunction

	// Energy at or above the threshold, often right at the edge.
	function automatic logic [ENERGY_W-1:0] loud_energy();
		logic [63:0] e;
		case ($urandom_range(0, 3))
			0:       e = cfg_shadow.energy_threshold + $urandom_range(0, 2);
			1:       e = cfg_shadow.energy_threshold + $urandom_range(0, 200000);
			2:       e = ENERGY_MAX;
			default: e = cfg_shadow.energy_threshold + any_energy();
		endcase
		if (e > ENERGY_MAX)
			e = ENERGY_MAX;
		return e[ENERGY_W-1:0];
	endfunction

	// Energy strictly below a nonzero threshold.
	function automatic logic [ENERGY_W-1:0] quiet_energy();
		logic [63:0] thr;
		logic [63:0] e;
		thr = cfg_shadow.energy_threshold;
		if ($urandom_range(0, 1))
			e = thr - 1 - ($urandom_range(0, 2) % thr);
		else
			e = any_energy() % thr;
		return e[ENERGY_W-1:0];
	endfunction

	function automatic frame_t plain_frame(input logic vad, input logic [ENERGY_W-1:0] e,
	                                       input int n);
		frame_t f;
		f.op            = OP_FRAME;
		f.vad_positive  = vad;
		f.frame_energy  = e;
		f.valid_samples = n[VALID_W-1:0];
		return f;
	endfunction

	// Every field but op drawn at random over its full width.
	function automatic frame_t raw_beat(input logic op);
		frame_t f;
		f.op            = op;
		f.vad_positive  = 1'($urandom_range(0, 1));
		f.frame_energy  = any_energy();
		f.valid_samples = VALID_W'($urandom_range(0, 511));
		return f;
	endfunction

	function automatic frame_t speech_frame(input bit talk);
		frame_t f;
		f.op            = OP_FRAME;
		f.valid_samples = ($urandom_range(0, 9) == 0) ? VALID_W'($urandom_range(0, 511)) :
		                  VALID_W'(FRAME_LEN_DEF);
		if (talk) begin
			f.vad_positive = 1'b1;
			f.frame_energy = loud_energy();
		end else if (cfg_shadow.energy_threshold == 0 || $urandom_range(0, 1)) begin
			f.vad_positive = 1'b0;
			f.frame_energy = $urandom_range(0, 1) ? loud_energy() : any_energy();
		end else begin
			f.vad_positive = 1'b1;
			f.frame_energy = quiet_energy();
		end
		return f;
	endfunction

	// Alternate talk spurts and pauses of random length, sprinkled with raw noise.
	task automatic queue_random_frames(input int count);
		int left;
		int seg;
		bit talk;
		left = count;
		while (left > 0) begin
			talk = $urandom_range(0, 1);
			seg  = talk ? $urandom_range(1, 30) : $urandom_range(1, 45);
			for (int k = 0; k < seg && left > 0; k++) begin
				if ($urandom_range(0, 6) == 0)
					add_frame(raw_beat(OP_FRAME));
				else
					add_frame(speech_frame(talk));
				left--;
			end
		end
	endtask

	// Writes go out back to back; the caller lowers the enable.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
	endtask

	task automatic set_config(input cfg_t c);
		write_reg(CFG_ENERGY_THRESHOLD, CFG_DATA_W'(c.energy_threshold));
		write_reg(CFG_START_RUN_FRAMES, CFG_DATA_W'(c.start_run_frames));
		write_reg(CFG_SILENCE_SAMPLES, CFG_DATA_W'(c.silence_samples));
		write_reg(CFG_MAX_UTTERANCE, CFG_DATA_W'(c.max_utterance_samples));
		write_reg(CFG_PREROLL_LIMIT, CFG_DATA_W'(c.preroll_limit));
		@(negedge clk);
		cfg_we     <= 1'b0;
		cfg_shadow  = c;
	endtask

	// Hold until every beat is in, every record is out, and the pipe has flushed.
	task automatic wait_idle();
		while (frame_q.size() != 0 || in_valid || pending_utterances.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Driver: present a new beat at the falling edge once the previous one was taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (frame_q.size() == 0) begin
				in_valid <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				// start an idle burst; send_gap holds what is left of it
				send_gap = $urandom_range(0, 7);
				in_valid <= 1'b0;
			end else begin
				in_data  <= frame_q[0];
				frame_q.delete(0);
				in_valid <= 1'b1;
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off so the block backs up.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (long_hold_go && !hold_served) begin
			hold_served = 1'b1;
			stall_left  = LONG_HOLD - 1;
			out_ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 7);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor: check the outgoing beat first, then predict from the incoming one.
	// A beat taken at this edge cannot produce a record at the same edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (pending_utterances.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected record: id %0d start %0d end %0d reason %0d",
						         out_data.utterance_id, out_data.first_pos,
						         out_data.stop_pos, out_data.reason);
				end else begin
					want = pending_utterances[0];
					pending_utterances.delete(0);
					if (out_data.utterance_id !== want.utterance_id ||
					    out_data.first_pos !== want.first_pos ||
					    out_data.stop_pos !== want.stop_pos ||
					    out_data.reason !== want.reason) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"record mismatch: expected id %0d start %0d end %0d ",
							          "reason %0d, got id %0d start %0d end %0d reason %0d"},
							         want.utterance_id, want.first_pos, want.stop_pos,
							         want.reason, out_data.utterance_id, out_data.first_pos,
							         out_data.stop_pos, out_data.reason);
					end
				end
			end
			if (in_valid && in_ready)
				advance_endpointer(in_data);
		end
	end

	// Watchdog
	initial begin : watchdog
		int cyc;
		cyc = 0;
		while (cyc < LIMIT_CYCLES) begin
			@(posedge clk);
			cyc++;
		end
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin : main
		cfg_t c;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: threshold edges, full-width energy, empty and oversized frames,
		// an open, a split with the cut before the start, a split at an unvoiced
		// frame inside the utterance, then a silence close.
		set_config('{energy_threshold: 39'd1000, start_run_frames: 3'd2,
		             silence_samples: 14'd640, max_utterance_samples: 18'd1600,
		             preroll_limit: 13'd480});
		add_frame(plain_frame(1'b0, '0, 0));
		add_frame(plain_frame(1'b1, ENERGY_MAX[ENERGY_W-1:0], 511));
		add_frame(plain_frame(1'b1, 39'd999, FRAME_LEN_DEF));
		add_frame(plain_frame(1'b1, 39'd1000, FRAME_LEN_DEF));
		add_frame(plain_frame(1'b1, 39'd1000, FRAME_LEN_DEF));
		repeat (5) add_frame(plain_frame(1'b1, 39'd5000, FRAME_LEN_DEF));
		add_frame(plain_frame(1'b0, ENERGY_MAX[ENERGY_W-1:0], FRAME_LEN_DEF));
		repeat (3) add_frame(plain_frame(1'b1, 39'd5000, FRAME_LEN_DEF));
		repeat (2) add_frame(plain_frame(1'b0, '0, FRAME_LEN_DEF));
		wait_idle();

		// Empty preroll: every open spends an id but nothing is held.
		set_config('{energy_threshold: 39'd1000, start_run_frames: 3'd1,
		             silence_samples: 14'd640, max_utterance_samples: 18'd1600,
		             preroll_limit: 13'd0});
		repeat (3) add_frame(plain_frame(1'b1, 39'd2000, FRAME_LEN_DEF));
		wait_idle();

		// Zero length limit: each split flushes all held audio.
		set_config('{energy_threshold: 39'd1000, start_run_frames: 3'd1,
		             silence_samples: 14'd640, max_utterance_samples: 18'd0,
		             preroll_limit: 13'd480});
		repeat (2) add_frame(plain_frame(1'b1, 39'd2000, FRAME_LEN_DEF));
		add_frame(plain_frame(1'b1, 39'd2000, 0));
		add_frame(plain_frame(1'b0, 39'd2000, FRAME_LEN_DEF));

		// Random phases over a spread of settings, extremes included.
		for (int p = 0; p < 6; p++) begin
			wait_idle();
			case (p)
				0: c = '{energy_threshold: 39'd3436, start_run_frames: 3'd5,
				         silence_samples: 14'd1, max_utterance_samples: 18'd320,
				         preroll_limit: 13'd8000};
				1: c = '{energy_threshold: 39'd0, start_run_frames: 3'd1,
				         silence_samples: 14'd16000, max_utterance_samples: 18'd3000,
				         preroll_limit: 13'd100};
				2: c = '{energy_threshold: ENERGY_HIGH[ENERGY_W-1:0], start_run_frames: 3'd7,
				         silence_samples: 14'd960, max_utterance_samples: 18'd4000,
				         preroll_limit: 13'd4800};
				3: c = '{energy_threshold: ENERGY_THRESHOLD_RST, start_run_frames: START_RUN_RST,
				         silence_samples: SILENCE_RST, max_utterance_samples: MAX_UTT_RST,
				         preroll_limit: PREROLL_RST};
				4: begin
					c = '{energy_threshold: '0, start_run_frames: 3'd3,
					      silence_samples: 14'd1600, max_utterance_samples: 18'd240000,
					      preroll_limit: 13'd8000};
					c.energy_threshold = ENERGY_W'(any_energy() % (ENERGY_HIGH + 1));
				end
				default: c = '{energy_threshold: 39'd5000, start_run_frames: 3'd2,
				               silence_samples: 14'd320, max_utterance_samples: 18'd1000,
				               preroll_limit: 13'd1000};
			endcase
			set_config(c);
			// frequent splits in the first phase make the long hold back up the input
			if (p == 0)
				long_hold_go = 1'b1;
			if (p == 5)
				no_idle = 1'b1;
			queue_random_frames(ITEMS_PER_PHASE);
		end

		// End of stream: flush, a repeated finish, then frames that arrive too late.
		add_frame(raw_beat(OP_FINISH));
		add_frame(raw_beat(OP_FINISH));
		repeat (15) add_frame(raw_beat(OP_FRAME));
		add_frame(raw_beat(OP_FINISH));
		repeat (3) add_frame(speech_frame(1'b1));
		wait_idle();

		if (mismatches == 0 && pending_utterances.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+design
design/sue_pkg.sv
design/sue_core.sv
design/sue_outq.sv
design/speech_utterance_endpointer_top.sv
tb/sv/tb_top.sv
